// File: hdl/arp_request_responder_macros.svh
// assertion macros for the arp request responder
`ifndef ARP_REQUEST_RESPONDER_MACROS_SVH
`define ARP_REQUEST_RESPONDER_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define ARPR_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("arpr assertion failed");

// next-cycle implication
`define ARPR_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("arpr assertion failed");

`else

`define ARPR_ASSERT_IMP(label, clk, rst, ante, cons)
`define ARPR_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

// File: hdl/arpr_pkg.sv
// shared types, constants and helper functions of the arp request responder
package arpr_pkg;

   localparam int FRAME_LEN = 42;
   localparam int ADDR_W    = 6;
   localparam int CSR_IDX_W = 2;
   localparam int MAC_W     = 48;
   localparam int IP_W      = 32;

   localparam logic [ADDR_W-1:0] LAST_POS = ADDR_W'(FRAME_LEN - 1);
   localparam logic [ADDR_W-1:0] FULL_CNT = ADDR_W'(FRAME_LEN);

   // arp field values
   localparam logic [15:0] ARP_HTYPE_ETH    = 16'h0001;
   localparam logic [15:0] ARP_PTYPE_IPV4   = 16'h0800;
   localparam logic [7:0]  ARP_MAC_ADDR_LEN = 8'd6;
   localparam logic [7:0]  ARP_PLEN         = 8'd4;
   localparam logic [15:0] ARP_OP_REQUEST   = 16'h0001;
   localparam logic [15:0] ARP_OP_REPLY     = 16'h0002;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LOCAL_MAC = 2'd0,
      CSR_LOCAL_IP  = 2'd1
   } csr_reg_type;

   typedef enum logic {
      TX_IDLE,
      TX_REPLY
   } tx_state_type;

   typedef enum logic [1:0] {
      SRC_MEM,
      SRC_MAC,
      SRC_IP,
      SRC_CONST
   } src_sel_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
   } mem_wr_type;

   typedef struct packed {
      src_sel_type       sel;
      logic [ADDR_W-1:0] addr;
      logic [2:0]        k;
      logic [7:0]        value;
   } reply_map_type;

   // 1 when a received byte at position idx agrees with what a request to us needs
   function automatic logic check_byte(input logic [ADDR_W-1:0] idx,
                                       input logic [7:0] b,
                                       input logic [IP_W-1:0] ip);
      logic ok;
      case (idx)
         6'd14:   ok = (b == ARP_HTYPE_ETH[15:8]);
         6'd15:   ok = (b == ARP_HTYPE_ETH[7:0]);
         6'd16:   ok = (b == ARP_PTYPE_IPV4[15:8]);
         6'd17:   ok = (b == ARP_PTYPE_IPV4[7:0]);
         6'd18:   ok = (b == ARP_MAC_ADDR_LEN);
         6'd19:   ok = (b == ARP_PLEN);
         6'd20:   ok = (b == ARP_OP_REQUEST[15:8]);
         6'd21:   ok = (b == ARP_OP_REQUEST[7:0]);
         6'd38:   ok = (b == ip[31:24]);
         6'd39:   ok = (b == ip[23:16]);
         6'd40:   ok = (b == ip[15:8]);
         6'd41:   ok = (b == ip[7:0]);
         default: ok = 1'b1;
      endcase
      return ok;
   endfunction

   // where reply byte p comes from
   function automatic reply_map_type reply_map(input logic [ADDR_W-1:0] p);
      reply_map_type m;
      logic [ADDR_W-1:0] d;
      m = '{sel: SRC_MEM, addr: '0, k: '0, value: '0};
      d = '0;
      if (p < 6'd6) begin
         m.addr = p + 6'd6;
      end else if (p < 6'd12) begin
         d = p - 6'd6;
         m.sel = SRC_MAC;
         m.k   = d[2:0];
      end else if (p == 6'd20) begin
         m.sel   = SRC_CONST;
         m.value = ARP_OP_REPLY[15:8];
      end else if (p == 6'd21) begin
         m.sel   = SRC_CONST;
         m.value = ARP_OP_REPLY[7:0];
      end else if (p >= 6'd22 && p < 6'd28) begin
         d = p - 6'd22;
         m.sel = SRC_MAC;
         m.k   = d[2:0];
      end else if (p >= 6'd28 && p < 6'd32) begin
         d = p - 6'd28;
         m.sel = SRC_IP;
         m.k   = d[2:0];
      end else if (p >= 6'd32 && p < FULL_CNT) begin
         m.addr = p - 6'd10;
      end else if (p < FULL_CNT) begin
         m.addr = p;
      end
      return m;
   endfunction

endpackage

// File: hdl/arpr_mem.sv
// frame store: 42 bytes, one write port, one registered read port
module arpr_mem (
   input  logic                             clock,
   input  arpr_pkg::mem_wr_type             wr,
   input  logic [arpr_pkg::ADDR_W-1:0]      rd_addr,
   output logic [7:0]                       rd_data
);

   logic [7:0] mem [arpr_pkg::FRAME_LEN];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/arpr_rx.sv
// receive side: byte counter, store writes and running request check
module arpr_rx (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            accept,
   input  logic [7:0]                      rx_byte,
   input  logic                            rx_last,
   input  logic [arpr_pkg::IP_W-1:0]       local_ip,
   output arpr_pkg::mem_wr_type            wr,
   output logic                            answer
);

   logic [arpr_pkg::ADDR_W-1:0] count_ff, count_in;
   logic                        ok_ff, ok_in;
   logic                        storing;
   logic                        match;

   assign storing = (count_ff < arpr_pkg::FULL_CNT);
   assign match   = arpr_pkg::check_byte(count_ff, rx_byte, local_ip);

   always_comb begin
      wr.en   = accept && storing;
      wr.addr = count_ff;
      wr.data = rx_byte;
   end

   always_comb begin
      count_in = count_ff;
      ok_in    = ok_ff;
      if (accept) begin
         if (rx_last) begin
            count_in = '0;
         end else if (storing) begin
            count_in = count_ff + 1'b1;
            ok_in    = (count_ff == '0) ? match : (ok_ff && match);
         end
      end
   end

   // byte 41 arriving as last byte still has its own check to fold in
   assign answer = accept && rx_last &&
                   (((count_ff == arpr_pkg::LAST_POS) && ok_ff && match) ||
                    ((count_ff == arpr_pkg::FULL_CNT) && ok_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ok_ff    <= 1'b0;
      end else begin
         count_ff <= count_in;
         ok_ff    <= ok_in;
      end
   end

endmodule

// File: hdl/arpr_tx.sv
// reply sequencer: walks the 42 reply positions, reading the store and merging local fields
module arpr_tx (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic                            rsp_stall,
   input  logic [7:0]                      rd_data,
   input  logic [arpr_pkg::MAC_W-1:0]      local_mac,
   input  logic [arpr_pkg::IP_W-1:0]       local_ip,
   output logic [arpr_pkg::ADDR_W-1:0]     rd_addr,
   output logic                            rsp_valid,
   output logic [7:0]                      tx_byte,
   output logic                            tx_last
);

   arpr_pkg::tx_state_type        state_ff, state_in;
   logic [arpr_pkg::ADDR_W-1:0]   pos_ff, pos_in;
   logic                          advance;
   arpr_pkg::reply_map_type       cur_map, rd_map;
   logic [arpr_pkg::MAC_W-1:0]    mac_sh;
   logic [arpr_pkg::IP_W-1:0]     ip_sh;
   logic [2:0]                    mac_k;
   logic [1:0]                    ip_k;

   assign tx_last = (pos_ff == arpr_pkg::LAST_POS);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         arpr_pkg::TX_IDLE: begin
            if (start) begin
               state_in = arpr_pkg::TX_REPLY;
            end
         end
         arpr_pkg::TX_REPLY: begin
            if (!rsp_stall && tx_last) begin
               state_in = arpr_pkg::TX_IDLE;
            end
         end
         default: state_in = arpr_pkg::TX_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid = 1'b0;
      advance   = 1'b0;
      pos_in    = pos_ff;
      case (state_ff)
         arpr_pkg::TX_IDLE: begin
            pos_in = '0;
         end
         arpr_pkg::TX_REPLY: begin
            rsp_valid = 1'b1;
            advance   = !rsp_stall;
            if (advance) begin
               pos_in = pos_ff + 1'b1;
            end
         end
         default: pos_in = '0;
      endcase
   end

   // read ahead so the data for the shown position is always in the read register
   always_comb begin
      rd_map  = arpr_pkg::reply_map(pos_in);
      rd_addr = rd_map.addr;
   end

   always_comb begin
      cur_map = arpr_pkg::reply_map(pos_ff);
      mac_k   = 3'd5 - cur_map.k;
      ip_k    = 2'd3 - cur_map.k[1:0];
      mac_sh  = local_mac >> {mac_k, 3'b000};
      ip_sh   = local_ip >> {ip_k, 3'b000};
      case (cur_map.sel)
         arpr_pkg::SRC_MEM:   tx_byte = rd_data;
         arpr_pkg::SRC_MAC:   tx_byte = mac_sh[7:0];
         arpr_pkg::SRC_IP:    tx_byte = ip_sh[7:0];
         arpr_pkg::SRC_CONST: tx_byte = cur_map.value;
         default:             tx_byte = rd_data;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= arpr_pkg::TX_IDLE;
         pos_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
      end
   end

endmodule

// File: hdl/arp_request_responder.sv
// top level of the arp request responder: config registers, store, receive and reply
// Frame bytes are taken one per cycle while req_stall is low, and the first 42 go into
// a small frame memory while the request checks run byte by byte as they arrive. When
// the last byte of an ARP request for local_ip is accepted, the 42-byte reply streams
// out of rsp_ one byte per cycle while rsp_stall is low, starting the next cycle, read
// position by position from that memory (one registered read per cycle). While a reply
// is going out req_stall is held high, so no new frame bytes are taken. Configuration
// writes are always ready and take effect the next cycle.
module arp_request_responder (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [7:0]                          req_rx_byte,
   input  logic                                req_rx_last,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [7:0]                          rsp_tx_byte,
   output logic                                rsp_tx_last,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [arpr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [arpr_pkg::MAC_W-1:0]          csr_data
);

   `include "arp_request_responder_macros.svh"

   logic [arpr_pkg::MAC_W-1:0]  mac_ff, mac_in;
   logic [arpr_pkg::IP_W-1:0]   ip_ff, ip_in;
   logic                        req_accept;
   logic                        answer;
   arpr_pkg::mem_wr_type        wr;
   logic [arpr_pkg::ADDR_W-1:0] rd_addr;
   logic [7:0]                  rd_data;

   assign csr_ready  = 1'b1;
   assign req_stall  = rsp_valid;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      mac_in = mac_ff;
      ip_in  = ip_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            arpr_pkg::CSR_LOCAL_MAC: mac_in = csr_data;
            arpr_pkg::CSR_LOCAL_IP:  ip_in  = csr_data[arpr_pkg::IP_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mac_ff <= '0;
         ip_ff  <= '0;
      end else begin
         mac_ff <= mac_in;
         ip_ff  <= ip_in;
      end
   end

   arpr_rx u_rx (
      .clock    (clock),
      .reset    (reset),
      .accept   (req_accept),
      .rx_byte  (req_rx_byte),
      .rx_last  (req_rx_last),
      .local_ip (ip_ff),
      .wr       (wr),
      .answer   (answer)
   );

   arpr_mem u_mem (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   arpr_tx u_tx (
      .clock     (clock),
      .reset     (reset),
      .start     (answer),
      .rsp_stall (rsp_stall),
      .rd_data   (rd_data),
      .local_mac (mac_ff),
      .local_ip  (ip_ff),
      .rd_addr   (rd_addr),
      .rsp_valid (rsp_valid),
      .tx_byte   (rsp_tx_byte),
      .tx_last   (rsp_tx_last)
   );

   // reply ends right after its last byte is taken
   `ARPR_ASSERT_NXT(a_reply_ends, clock, reset, rsp_valid && rsp_tx_last && !rsp_stall, !rsp_valid)
   // a reply only starts after an accepted last byte
   `ARPR_ASSERT_IMP(a_reply_cause, clock, reset, $rose(rsp_valid), $past(req_accept && req_rx_last))
   // no store write while a reply is being read out
   `ARPR_ASSERT_IMP(a_no_write_in_reply, clock, reset, rsp_valid, !wr.en)

endmodule
